@@ sv/llwt_pkg.sv @@
package llwt_pkg;

   localparam int IDX_W   = 4;
   localparam int CNT_W   = 5;
   localparam int LAT_W   = 32;
   localparam int TOT_W   = 48;
   localparam int LAYER_W = 32;
   localparam int REACH   = 16;

   localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(16);

   typedef enum logic {
      STATUS_UPDATED  = 1'b0,
      STATUS_REJECTED = 1'b1
   } status_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic             valid;
      logic             has;
      logic [IDX_W-1:0] idx;
      logic [LAT_W-1:0] lat;
   } cand_type;

   typedef struct packed {
      logic             en;
      logic [LAT_W-1:0] latency;
      logic             layer_done;
   } upd_type;

   typedef struct packed {
      logic [LAT_W-1:0]   min_lat;
      logic [LAT_W-1:0]   max_lat;
      logic [TOT_W-1:0]   total;
      logic [LAYER_W-1:0] layers;
   } stats_type;

endpackage

@@ sv/llwt_cell.sv @@
module llwt_cell
   import llwt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             cell_active,
   input  upd_type          upd,
   input  cand_type         cand_in,
   output cand_type         cand_out,
   output stats_type        stats
);

   logic [LAT_W-1:0]   last_ff, last_in;
   logic [LAT_W-1:0]   min_ff, min_in;
   logic [LAT_W-1:0]   max_ff, max_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [LAYER_W-1:0] layers_ff, layers_in;
   cand_type           cand_ff, cand_in_next;
   logic [TOT_W:0]     total_sum;

   always_comb begin
      total_sum = {1'b0, total_ff} + (TOT_W+1)'(upd.latency);
      last_in   = last_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      total_in  = total_ff;
      layers_in = layers_ff;
      if (upd.en) begin
         last_in = upd.latency;
         if (upd.layer_done && (layers_ff != {LAYER_W{1'b1}})) begin
            layers_in = layers_ff + LAYER_W'(1);
         end
         if ((upd.latency < min_ff) || (min_ff == '0)) begin
            min_in = upd.latency;
         end
         if (upd.latency > max_ff) begin
            max_in = upd.latency;
         end
         total_in = total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];
      end
   end

   // keep the lower latency, first cell wins on ties
   always_comb begin
      cand_in_next = cand_in;
      if (cand_in.valid && cell_active && (!cand_in.has || (last_ff < cand_in.lat))) begin
         cand_in_next.has = 1'b1;
         cand_in_next.idx = cell_idx;
         cand_in_next.lat = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         total_ff  <= '0;
         layers_ff <= '0;
         cand_ff   <= '0;
      end else begin
         last_ff   <= last_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         total_ff  <= total_in;
         layers_ff <= layers_in;
         cand_ff   <= cand_in_next;
      end
   end

   assign cand_out      = cand_ff;
   assign stats.min_lat = min_ff;
   assign stats.max_lat = max_ff;
   assign stats.total   = total_ff;
   assign stats.layers  = layers_ff;

endmodule

@@ sv/least_latency_worker_tracker.sv @@
// channel   ports                                   transfer
// input     start, busy, req_*                      start high while busy low
// result    rsp_strobe, rsp_*                       one cycle with rsp_strobe high
// config    psel, penable, pwrite, paddr, pwdata    psel & penable & pwrite & pready
//
// the stats update at the start edge, then go_ff sends a scan token that walks one cell per
// cycle down the chain; the result is out when the token leaves the last cell
// busy is high from the start edge through the result cycle; no start is taken meanwhile
// synchronous reset clears all worker stats and sets active_workers to 16
// results cannot be held off, every result is a transfer in its strobe cycle
module least_latency_worker_tracker
   import llwt_pkg::*;
#(
   parameter int MAX_WORKERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [IDX_W-1:0]   req_worker_index,
   input  logic [LAT_W-1:0]   req_latency,
   input  logic               req_layer_done,
   output logic               rsp_strobe,
   output logic               rsp_status,
   output logic [IDX_W-1:0]   rsp_fastest_worker,
   output logic [LAT_W-1:0]   rsp_worker_min,
   output logic [LAT_W-1:0]   rsp_worker_max,
   output logic [TOT_W-1:0]   rsp_worker_total,
   output logic [LAYER_W-1:0] rsp_worker_layers,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int CELLS  = (MAX_WORKERS < REACH) ? MAX_WORKERS : REACH;
   localparam int CELL_W = $clog2(CELLS);

   logic [CNT_W-1:0] active_ff;
   logic             busy_ff, busy_in;
   logic             go_ff;
   logic [IDX_W-1:0] idx_ff;
   status_type       status_ff, status_in;
   logic [CNT_W-1:0] in_use;
   logic             accept;
   logic             csr_write;
   cand_type         chain [CELLS+1];
   stats_type        stats [CELLS];
   stats_type        sel_stats;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == 2'd0);
   assign prdata    = (paddr == 2'd0) ? {{(32-CNT_W){1'b0}}, active_ff} : '0;

   assign in_use = (active_ff > CNT_W'(CELLS)) ? CNT_W'(CELLS) : active_ff;
   assign accept = start && !busy_ff;

   always_comb begin
      status_in = ({1'b0, req_worker_index} < in_use) ? STATUS_UPDATED : STATUS_REJECTED;
      busy_in   = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (chain[CELLS].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         busy_ff   <= 1'b0;
         go_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            active_ff <= pwdata[CNT_W-1:0];
         end
         busy_ff <= busy_in;
         go_ff   <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff    <= req_worker_index;
         status_ff <= status_in;
      end
   end

   assign chain[0] = '{valid: go_ff, has: 1'b0, idx: '0, lat: '0};

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      upd_type upd;
      logic    cell_active;

      assign cell_active    = CNT_W'(i) < in_use;
      assign upd.en         = accept && (status_in == STATUS_UPDATED)
                              && (req_worker_index == IDX_W'(i));
      assign upd.latency    = req_latency;
      assign upd.layer_done = req_layer_done;

      llwt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .cell_active (cell_active),
         .upd         (upd),
         .cand_in     (chain[i]),
         .cand_out    (chain[i+1]),
         .stats       (stats[i])
      );
   end

   assign sel_stats = stats[idx_ff[CELL_W-1:0]];

   assign busy               = busy_ff;
   assign rsp_strobe         = chain[CELLS].valid;
   assign rsp_status         = status_ff;
   assign rsp_fastest_worker = chain[CELLS].has ? chain[CELLS].idx : '0;
   assign rsp_worker_min     = (status_ff == STATUS_UPDATED) ? sel_stats.min_lat : '0;
   assign rsp_worker_max     = (status_ff == STATUS_UPDATED) ? sel_stats.max_lat : '0;
   assign rsp_worker_total   = (status_ff == STATUS_UPDATED) ? sel_stats.total : '0;
   assign rsp_worker_layers  = (status_ff == STATUS_UPDATED) ? sel_stats.layers : '0;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import llwt_pkg::*;

   localparam logic [1:0] ACTIVE_WORKERS_ADDR = 2'd0;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] best;
      stats_type        stats;
   } tracker_result_type;

   typedef struct packed {
      bit                 is_cfg;
      logic [CNT_W-1:0]   cfg;
      logic [IDX_W-1:0]   idx;
      logic [LAT_W-1:0]   lat;
      logic               done;
      bit                 typed;
      tracker_result_type want;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [IDX_W-1:0]   req_worker_index = '0;
   logic [LAT_W-1:0]   req_latency = '0;
   logic               req_layer_done = 1'b0;
   logic               rsp_strobe;
   logic               rsp_status;
   logic [IDX_W-1:0]   rsp_fastest_worker;
   logic [LAT_W-1:0]   rsp_worker_min;
   logic [LAT_W-1:0]   rsp_worker_max;
   logic [TOT_W-1:0]   rsp_worker_total;
   logic [LAYER_W-1:0] rsp_worker_layers;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [1:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   logic [LAT_W-1:0]   seen_last [REACH];
   logic [LAT_W-1:0]   seen_min [REACH];
   logic [LAT_W-1:0]   seen_max [REACH];
   logic [TOT_W-1:0]   seen_total [REACH];
   logic [LAYER_W-1:0] seen_layers [REACH];
   logic [CNT_W-1:0]   active_cfg;

   tracker_result_type pending_reports [$];
   tracker_result_type oldest_report;
   script_row_type     directed_script [$];
   int                 mismatches = 0;

   least_latency_worker_tracker #(.MAX_WORKERS(16)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_worker_index(req_worker_index),
      .req_latency(req_latency),
      .req_layer_done(req_layer_done),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_fastest_worker(rsp_fastest_worker),
      .rsp_worker_min(rsp_worker_min),
      .rsp_worker_max(rsp_worker_max),
      .rsp_worker_total(rsp_worker_total),
      .rsp_worker_layers(rsp_worker_layers),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic tracker_result_type track_report(input logic [IDX_W-1:0] idx,
                                                       input logic [LAT_W-1:0] lat,
                                                       input logic done);
      tracker_result_type r;
      int unsigned        n;
      logic [TOT_W:0]     sum;
      n = (active_cfg > REACH) ? REACH : active_cfg;
      r = '0;
      if (idx >= n) begin
         r.status = STATUS_REJECTED;
      end else begin
         r.status = STATUS_UPDATED;
         seen_last[idx] = lat;
         if (done && seen_layers[idx] != '1) seen_layers[idx] = seen_layers[idx] + 1'b1;
         if (lat < seen_min[idx] || seen_min[idx] == '0) seen_min[idx] = lat;
         if (lat > seen_max[idx]) seen_max[idx] = lat;
         sum = {1'b0, seen_total[idx]} + lat;
         seen_total[idx] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
         r.stats.min_lat = seen_min[idx];
         r.stats.max_lat = seen_max[idx];
         r.stats.total = seen_total[idx];
         r.stats.layers = seen_layers[idx];
      end
      for (int i = 1; i < n; i++) begin
         if (seen_last[i] < seen_last[r.best]) r.best = i[IDX_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_status, 0);
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_status !== oldest_report.status)
               report_mismatch("status", rsp_status, oldest_report.status);
            if (rsp_fastest_worker !== oldest_report.best)
               report_mismatch("fastest_worker", rsp_fastest_worker, oldest_report.best);
            if (rsp_worker_min !== oldest_report.stats.min_lat)
               report_mismatch("worker_min", rsp_worker_min, oldest_report.stats.min_lat);
            if (rsp_worker_max !== oldest_report.stats.max_lat)
               report_mismatch("worker_max", rsp_worker_max, oldest_report.stats.max_lat);
            if (rsp_worker_total !== oldest_report.stats.total)
               report_mismatch("worker_total", rsp_worker_total, oldest_report.stats.total);
            if (rsp_worker_layers !== oldest_report.stats.layers)
               report_mismatch("worker_layers", rsp_worker_layers,
                               oldest_report.stats.layers);
         end
      end
   end

   task automatic send_report(input logic [IDX_W-1:0] idx, input logic [LAT_W-1:0] lat,
                              input logic done, input bit typed,
                              input tracker_result_type want);
      tracker_result_type predicted;
      req_worker_index <= idx;
      req_latency <= lat;
      req_layer_done <= done;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = track_report(idx, lat, done);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic hold_off(input bit to_idle, input int cycles);
      start <= 1'b0;
      if (to_idle) begin
         @(posedge clock);
         while (busy) @(posedge clock);
      end
      repeat (cycles) @(posedge clock);
   endtask

   task automatic configure(input logic [CNT_W-1:0] value);
      logic [31:0] word;
      settle();
      word = ($urandom & 32'hFFFF_FFE0) | {27'd0, value};
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ACTIVE_WORKERS_ADDR;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      active_cfg = value;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {27'd0, active_cfg})
         report_mismatch("active_workers readback", prdata, {27'd0, active_cfg});
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int count, input bit with_idle);
      int unsigned      n;
      int unsigned      roll;
      logic [IDX_W-1:0] idx;
      logic [LAT_W-1:0] lat;
      for (int k = 0; k < count; k++) begin
         n = (active_cfg > REACH) ? REACH : active_cfg;
         if (n != 0 && $urandom_range(0, 9) < 8) idx = IDX_W'($urandom_range(0, n - 1));
         else idx = IDX_W'($urandom_range(0, REACH - 1));
         case ($urandom_range(0, 9))
            0: lat = '0;
            1: lat = '1;
            2: lat = 32'hFFFF_FFFF - $urandom_range(0, 15);
            3, 4: lat = $urandom_range(0, 15);
            5: lat = $urandom_range(0, 1000);
            default: lat = $urandom;
         endcase
         send_report(idx, lat, 1'($urandom_range(0, 1)), 1'b0, '0);
         if (with_idle) begin
            roll = $urandom_range(0, 63);
            if (roll == 0) settle();
            else if (roll < 22) hold_off(1'($urandom_range(0, 1)), $urandom_range(1, 14));
         end
      end
   endtask

   function automatic void add_cfg(input logic [CNT_W-1:0] value);
      script_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg = value;
      directed_script.push_back(row);
   endfunction

   function automatic void add_report(input logic [IDX_W-1:0] idx,
                                      input logic [LAT_W-1:0] lat, input logic done);
      script_row_type row;
      row = '0;
      row.idx = idx;
      row.lat = lat;
      row.done = done;
      directed_script.push_back(row);
   endfunction

   function automatic void add_typed(input logic [IDX_W-1:0] idx,
                                     input logic [LAT_W-1:0] lat, input logic done,
                                     input status_type status, input logic [IDX_W-1:0] best,
                                     input logic [LAT_W-1:0] min_lat,
                                     input logic [LAT_W-1:0] max_lat,
                                     input logic [TOT_W-1:0] total,
                                     input logic [LAYER_W-1:0] layers);
      script_row_type row;
      row = '0;
      row.idx = idx;
      row.lat = lat;
      row.done = done;
      row.typed = 1'b1;
      row.want.status = status;
      row.want.best = best;
      row.want.stats.min_lat = min_lat;
      row.want.stats.max_lat = max_lat;
      row.want.stats.total = total;
      row.want.stats.layers = layers;
      directed_script.push_back(row);
   endfunction

   initial begin
      for (int i = 0; i < REACH; i++) begin
         seen_last[i] = '0;
         seen_min[i] = '0;
         seen_max[i] = '0;
         seen_total[i] = '0;
         seen_layers[i] = '0;
      end
      active_cfg = ACTIVE_RESET;

      add_typed(4'd0, 32'd100, 1'b1, STATUS_UPDATED, 4'd1, 32'd100, 32'd100, 48'd100, 32'd1);
      add_typed(4'd15, 32'hFFFF_FFFF, 1'b0, STATUS_UPDATED, 4'd1, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 48'h0000_FFFF_FFFF, 32'd0);
      // zero latency leaves the minimum unset
      add_typed(4'd3, 32'd0, 1'b1, STATUS_UPDATED, 4'd1, 32'd0, 32'd0, 48'd0, 32'd1);
      add_report(4'd3, 32'd50, 1'b0);
      add_report(4'd3, 32'd20, 1'b1);
      add_report(4'd3, 32'd90, 1'b0);
      add_report(4'd0, 32'd7, 1'b1);
      add_report(4'd15, 32'd1, 1'b1);
      add_report(4'd15, 32'hFFFF_FFFF, 1'b1);
      add_cfg(5'd4);
      add_typed(4'd4, 32'd123, 1'b1, STATUS_REJECTED, 4'd1, '0, '0, '0, '0);
      add_typed(4'd15, 32'd5, 1'b1, STATUS_REJECTED, 4'd1, '0, '0, '0, '0);
      add_report(4'd1, 32'd500, 1'b0);
      add_report(4'd2, 32'd400, 1'b1);
      add_report(4'd3, 32'd1, 1'b0);
      add_cfg(5'd1);
      add_report(4'd0, 32'd9, 1'b0);
      add_typed(4'd1, 32'd9, 1'b0, STATUS_REJECTED, 4'd0, '0, '0, '0, '0);
      // no active workers
      add_cfg(5'd0);
      add_typed(4'd0, 32'd10, 1'b1, STATUS_REJECTED, 4'd0, '0, '0, '0, '0);
      add_typed(4'd15, 32'hFFFF_FFFF, 1'b1, STATUS_REJECTED, 4'd0, '0, '0, '0, '0);
      // count above the index reach
      add_cfg(5'd31);
      add_report(4'd15, 32'd2, 1'b0);
      add_report(4'd14, 32'd0, 1'b1);
      add_report(4'd5, 32'hFFFF_FFFE, 1'b1);
      add_cfg(5'd16);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         if (directed_script[i].is_cfg) configure(directed_script[i].cfg);
         else send_report(directed_script[i].idx, directed_script[i].lat,
                          directed_script[i].done, directed_script[i].typed,
                          directed_script[i].want);
      end

      configure(5'd16);
      run_random(300, 1'b1);
      configure(5'd1);
      run_random(200, 1'b1);
      configure(5'd0);
      run_random(40, 1'b1);
      configure(5'd31);
      run_random(250, 1'b1);
      configure(5'd2);
      run_random(200, 1'b1);
      configure(CNT_W'($urandom_range(3, 15)));
      run_random(300, 1'b1);
      configure(CNT_W'($urandom_range(17, 30)));
      run_random(200, 1'b1);
      configure(CNT_W'($urandom_range(1, 16)));
      run_random(300, 1'b1);
      configure(5'd16);
      run_random(150, 1'b0);

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[least_latency_worker_tracker] OK");
      end else begin
         $display("[least_latency_worker_tracker] ERROR");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("[least_latency_worker_tracker] ERROR");
      $finish;
   end

endmodule
